>>> design/psd_pkg.sv
package psd_pkg;

	localparam int PosW    = 12;
	localparam int TolW    = 8;
	localparam int StepW   = 8;
	localparam int BudgetW = 16;
	localparam int ElapsW  = 17;
	localparam int CfgIdxW = 3;
	localparam int CfgDatW = 12;

	localparam logic [PosW-1:0]  FrontTargetRst = 12'd900;
	localparam logic [PosW-1:0]  BackTargetRst  = 12'd2750;
	localparam logic [TolW-1:0]  EndTolRst      = 8'd20;
	localparam logic [TolW-1:0]  MidTolRst      = 8'd25;
	localparam logic [StepW-1:0] StepMsRst      = 8'd10;

	localparam logic [CfgIdxW-1:0] CFG_FRONT_TARGET = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_BACK_TARGET  = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_END_TOL      = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_MID_TOL      = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_STEP_MS      = 3'd4;

	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_TICK  = 2'd1;
	localparam logic [1:0] REQ_ABORT = 2'd2;

	localparam logic [1:0] MODE_FRONT  = 2'd0;
	localparam logic [1:0] MODE_BACK   = 2'd1;
	localparam logic [1:0] MODE_MIDDLE = 2'd2;
	localparam logic [1:0] MODE_UNDEF  = 2'd3;

	localparam logic [1:0] DRV_STOP = 2'd0;
	localparam logic [1:0] DRV_FWD  = 2'd1;
	localparam logic [1:0] DRV_REV  = 2'd2;

	localparam logic [1:0] OUT_NONE    = 2'd0;
	localparam logic [1:0] OUT_REACHED = 2'd1;
	localparam logic [1:0] OUT_TIMEOUT = 2'd2;
	localparam logic [1:0] OUT_ABORT   = 2'd3;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [1:0]         move_mode;
		logic [BudgetW-1:0] budget_ms;
		logic [PosW-1:0]    position_sample;
	} psd_in_t;

	typedef struct packed {
		logic [1:0] drive;
		logic       busy_res;
		logic       done_res;
		logic [1:0] outcome;
	} psd_out_t;

	typedef struct packed {
		logic [PosW-1:0]  front_pos;
		logic [PosW-1:0]  back_pos;
		logic [TolW-1:0]  end_tolerance;
		logic [TolW-1:0]  middle_tolerance;
		logic [StepW-1:0] step_ms;
	} psd_cfg_t;

endpackage

>>> design/psd_cfg_regs.sv
module psd_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [psd_pkg::CfgIdxW-1:0]   wr_index,
	input  logic [psd_pkg::CfgDatW-1:0]   wr_data,
	output psd_pkg::psd_cfg_t             cfg
);
	import psd_pkg::*;

	psd_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.front_pos        <= FrontTargetRst;
			cfg_q.back_pos         <= BackTargetRst;
			cfg_q.end_tolerance    <= EndTolRst;
			cfg_q.middle_tolerance <= MidTolRst;
			cfg_q.step_ms          <= StepMsRst;
		end else if (wr_en) begin
			case (wr_index)
				CFG_FRONT_TARGET: cfg_q.front_pos        <= wr_data[PosW-1:0];
				CFG_BACK_TARGET:  cfg_q.back_pos         <= wr_data[PosW-1:0];
				CFG_END_TOL:      cfg_q.end_tolerance    <= wr_data[TolW-1:0];
				CFG_MID_TOL:      cfg_q.middle_tolerance <= wr_data[TolW-1:0];
				CFG_STEP_MS:      cfg_q.step_ms          <= wr_data[StepW-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/psd_core.sv
module psd_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  psd_pkg::psd_in_t   item,
	input  psd_pkg::psd_cfg_t  cfg,
	output psd_pkg::psd_out_t  result
);
	import psd_pkg::*;

	logic               running_q;
	logic [1:0]         mode_q;
	logic [ElapsW-1:0]  elapsed_q;
	logic [BudgetW-1:0] budget_q;
	logic [1:0]         drive_q;

	logic               running_d;
	logic [1:0]         mode_d;
	logic [ElapsW-1:0]  elapsed_d;
	logic [BudgetW-1:0] budget_d;
	logic [1:0]         drive_d;
	logic               done;
	logic [1:0]         outcome;

	logic [PosW:0]      front_lim;
	logic [PosW:0]      back_sum;
	logic [PosW:0]      mid_sum;
	logic [PosW-1:0]    mid;
	logic [PosW:0]      mid_lo_sum;
	logic [PosW:0]      mid_hi;
	logic [PosW:0]      samp;
	logic               arrived;
	logic [ElapsW-1:0]  elapsed_inc;

	assign samp        = {1'b0, item.position_sample};
	assign front_lim   = {1'b0, cfg.front_pos} + {5'd0, cfg.end_tolerance};
	assign back_sum    = samp + {5'd0, cfg.end_tolerance};
	assign mid_sum     = {1'b0, cfg.front_pos} + {1'b0, cfg.back_pos};
	assign mid         = mid_sum[PosW:1];
	assign mid_lo_sum  = samp + {5'd0, cfg.middle_tolerance};
	assign mid_hi      = {1'b0, mid} + {5'd0, cfg.middle_tolerance};
	assign elapsed_inc = elapsed_q + {9'd0, cfg.step_ms};

	always_comb begin
		case (mode_q)
			MODE_FRONT: arrived = samp <= front_lim;
			MODE_BACK:  arrived = back_sum >= {1'b0, cfg.back_pos};
			default:    arrived = (mid_lo_sum >= {1'b0, mid}) && (samp <= mid_hi);
		endcase
	end

	always_comb begin
		running_d = running_q;
		mode_d    = mode_q;
		elapsed_d = elapsed_q;
		budget_d  = budget_q;
		drive_d   = drive_q;
		done      = 1'b0;
		outcome   = OUT_NONE;
		case (item.req_type)
			REQ_START: begin
				if (item.move_mode != MODE_UNDEF) begin
					mode_d    = item.move_mode;
					budget_d  = item.budget_ms;
					elapsed_d = '0;
					if (item.budget_ms == '0) begin
						running_d = 1'b0;
						drive_d   = DRV_STOP;
						done      = 1'b1;
						outcome   = OUT_TIMEOUT;
					end else begin
						running_d = 1'b1;
						case (item.move_mode)
							MODE_FRONT: drive_d = DRV_FWD;
							MODE_BACK:  drive_d = DRV_REV;
							default:    drive_d = DRV_STOP;
						endcase
					end
				end
			end
			REQ_TICK: begin
				if (running_q) begin
					if (arrived) begin
						running_d = 1'b0;
						drive_d   = DRV_STOP;
						done      = 1'b1;
						outcome   = OUT_REACHED;
					end else begin
						if (mode_q == MODE_MIDDLE)
							drive_d = (item.position_sample < mid) ? DRV_REV : DRV_FWD;
						elapsed_d = elapsed_inc;
						if (elapsed_inc >= {1'b0, budget_q}) begin
							running_d = 1'b0;
							drive_d   = DRV_STOP;
							done      = 1'b1;
							outcome   = OUT_TIMEOUT;
						end
					end
				end
			end
			REQ_ABORT: begin
				if (running_q) begin
					running_d = 1'b0;
					drive_d   = DRV_STOP;
					done      = 1'b1;
					outcome   = OUT_ABORT;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			mode_q    <= MODE_FRONT;
			elapsed_q <= '0;
			budget_q  <= '0;
			drive_q   <= DRV_STOP;
		end else if (accept) begin
			running_q <= running_d;
			mode_q    <= mode_d;
			elapsed_q <= elapsed_d;
			budget_q  <= budget_d;
			drive_q   <= drive_d;
		end
	end

	assign result.drive    = drive_d;
	assign result.busy_res = running_d;
	assign result.done_res = done;
	assign result.outcome  = outcome;

endmodule

>>> design/psd_out_buf.sv
module psd_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  psd_pkg::psd_out_t  push_item,
	output logic               push_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output psd_pkg::psd_out_t  out_item
);
	import psd_pkg::*;

	logic     main_valid_q;
	logic     skid_valid_q;
	psd_out_t main_q;
	psd_out_t skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_valid_q && out_ready) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			if (main_valid_q)
				skid_valid_q <= 1'b1;
			else
				main_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_valid_q && out_ready) begin
			if (skid_valid_q)
				main_q <= skid_q;
			else if (push)
				main_q <= push_item;
		end else if (push) begin
			if (main_valid_q)
				skid_q <= push_item;
			else
				main_q <= push_item;
		end
	end

	assign push_ready = !skid_valid_q;
	assign out_valid  = main_valid_q;
	assign out_item   = main_q;

endmodule

>>> design/position_seek_with_deadband.sv
// Bang-bang position seek with deadband and timeout. Each item (start, sample
// tick or abort) yields one result; items may be offered every cycle. The move
// state updates in the accepting cycle and results queue in a two-entry
// output buffer, so item_ready drops only when both entries are held by a
// stalled result side. Configuration writes are always taken (cfg_ready is
// always high), act live on a move in progress, and indexes beyond step_ms
// are ignored.
module position_seek_with_deadband (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  psd_pkg::psd_in_t             item,
	output logic                         result_valid,
	input  logic                         result_ready,
	output psd_pkg::psd_out_t            result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [psd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [psd_pkg::CfgDatW-1:0]  cfg_data
);
	import psd_pkg::*;

	psd_cfg_t cfg;
	psd_out_t core_result;
	logic     accept;

	assign cfg_ready = 1'b1;
	assign accept    = item_valid && item_ready;

	psd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	psd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.cfg    (cfg),
		.result (core_result)
	);

	psd_out_buf u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_item  (core_result),
		.push_ready (item_ready),
		.out_valid  (result_valid),
		.out_ready  (result_ready),
		.out_item   (result)
	);

endmodule

>>> design/psd_checker.sv
module psd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               result_valid,
	input logic               result_ready,
	input psd_pkg::psd_out_t  result
);
	import psd_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_outcome_none: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.done_res |-> result.outcome == OUT_NONE)
		else $error("outcome without done");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.done_res |-> !result.busy_res && result.outcome != OUT_NONE)
		else $error("done result still busy or without outcome");

	a_idle_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.busy_res |-> result.drive == DRV_STOP)
		else $error("motor driven while idle");

endmodule

bind position_seek_with_deadband psd_checker u_psd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
